// File: rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants of the longest prefix route lookup unit.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // fixed field widths
  localparam int unsigned IndexW = 4;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 2;

  // default table depth
  localparam int unsigned LPM_TABLE_ENTRIES = 16;

  // request action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // one request as it travels along the chain
  typedef struct packed {
    logic              action;
    logic [IndexW-1:0] entry_index;
    logic              entry_enable;
    logic [AddrW-1:0]  prefix_in;
    logic [AddrW-1:0]  mask_in;
    logic [AddrW-1:0]  gateway_in;
    logic [PortW-1:0]  port_in;
    logic [AddrW-1:0]  lookup_addr;
  } req_t;

  // best match found so far
  typedef struct packed {
    logic              hit;
    logic [IndexW-1:0] match_index;
    logic [AddrW-1:0]  best_mask;
    logic [AddrW-1:0]  next_hop;
    logic [PortW-1:0]  out_port;
  } acc_t;

  localparam acc_t ACC_NONE = '{
    hit:         1'b0,
    match_index: '0,
    best_mask:   '0,
    next_hop:    '0,
    out_port:    '0
  };

endpackage

// File: rtl/lpm_req_if.sv
// ----------------------------------------------------------------------------
// lpm_req_if
// Request channel: table writes and address lookups.
// ----------------------------------------------------------------------------
interface lpm_req_if;
  import lpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [IndexW-1:0] entry_index;
  logic              entry_enable;
  logic [AddrW-1:0]  prefix_in;
  logic [AddrW-1:0]  mask_in;
  logic [AddrW-1:0]  gateway_in;
  logic [PortW-1:0]  port_in;
  logic [AddrW-1:0]  lookup_addr;

  modport source (
    output valid, action, entry_index, entry_enable, prefix_in, mask_in,
           gateway_in, port_in, lookup_addr,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, entry_enable, prefix_in, mask_in,
           gateway_in, port_in, lookup_addr,
    output ready
  );
endinterface

// File: rtl/lpm_res_if.sv
// ----------------------------------------------------------------------------
// lpm_res_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface lpm_res_if;
  import lpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [IndexW-1:0] match_index;
  logic [AddrW-1:0]  next_hop;
  logic [PortW-1:0]  out_port;

  modport source (
    output valid, hit, match_index, next_hop, out_port,
    input  ready
  );

  modport sink (
    input  valid, hit, match_index, next_hop, out_port,
    output ready
  );
endinterface

// File: rtl/longest_prefix_route_lookup_unit.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_unit
// IPv4 longest prefix route lookup over a chain of table slot cells.
// ----------------------------------------------------------------------------
// Path: from request accept to result valid, each request walks the chain
//   of slot cells, one cell per cycle while the chain advances.
// Throughput: one request per cycle; a result held at the output freezes
//   the whole chain until it is taken.
// Reset: clears all slot valid bits and the chain occupancy; stored entry
//   fields are not reset.
module longest_prefix_route_lookup_unit #(
  parameter int unsigned TABLE_ENTRIES = lpm_pkg::LPM_TABLE_ENTRIES
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lpm_req_if.sink   req_i,
  lpm_res_if.source res_o
);
  import lpm_pkg::*;

  logic valid_w [TABLE_ENTRIES+1];
  req_t req_w   [TABLE_ENTRIES+1];
  acc_t acc_w   [TABLE_ENTRIES+1];
  logic adv;

  // whole chain advances unless the output holds an untaken result
  assign adv = !valid_w[TABLE_ENTRIES] || res_o.ready;
  assign req_i.ready = adv;

  // chain input
  assign valid_w[0] = req_i.valid;
  assign acc_w[0]   = ACC_NONE;
  always_comb begin
    req_w[0].action       = req_i.action;
    req_w[0].entry_index  = req_i.entry_index;
    req_w[0].entry_enable = req_i.entry_enable;
    req_w[0].prefix_in    = req_i.prefix_in;
    req_w[0].mask_in      = req_i.mask_in;
    req_w[0].gateway_in   = req_i.gateway_in;
    req_w[0].port_in      = req_i.port_in;
    req_w[0].lookup_addr  = req_i.lookup_addr;
  end

  // one cell per table slot
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lpm_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .in_valid_i  (valid_w[g]),
      .in_req_i    (req_w[g]),
      .in_acc_i    (acc_w[g]),
      .out_valid_o (valid_w[g+1]),
      .out_req_o   (req_w[g+1]),
      .out_acc_o   (acc_w[g+1])
    );
  end

  // last cell register is the output register
  assign res_o.valid       = valid_w[TABLE_ENTRIES];
  assign res_o.hit         = acc_w[TABLE_ENTRIES].hit;
  assign res_o.match_index = acc_w[TABLE_ENTRIES].match_index;
  assign res_o.next_hop    = acc_w[TABLE_ENTRIES].next_hop;
  assign res_o.out_port    = acc_w[TABLE_ENTRIES].out_port;

endmodule

// File: rtl/lpm_cell.sv
// ----------------------------------------------------------------------------
// lpm_cell
// One routing table slot. Captures a write aimed at its slot, and updates
// the running best match of a passing lookup, then hands both on.
// ----------------------------------------------------------------------------
module lpm_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          in_valid_i,
  input  lpm_pkg::req_t in_req_i,
  input  lpm_pkg::acc_t in_acc_i,
  output logic          out_valid_o,
  output lpm_pkg::req_t out_req_o,
  output lpm_pkg::acc_t out_acc_o
);
  import lpm_pkg::*;

  localparam logic [AddrW-1:0]  CellId  = AddrW'(CELL_INDEX);
  localparam logic [IndexW-1:0] CellTag = CellId[IndexW-1:0];

  logic              valid_q;
  logic [AddrW-1:0]  prefix_q;
  logic [AddrW-1:0]  mask_q;
  logic [AddrW-1:0]  gateway_q;
  logic [PortW-1:0]  port_q;
  logic              out_valid_q;
  req_t              out_req_q;
  acc_t              out_acc_q;
  acc_t              acc_d;
  logic              wr_hit;
  logic              match;
  logic              take;

  // write aimed at this slot
  assign wr_hit = adv_i && in_valid_i && (in_req_i.action == ACT_WRITE) &&
                  ({{(AddrW-IndexW){1'b0}}, in_req_i.entry_index} == CellId);

  // lookup against the stored entry, later slot wins a tie
  assign match = in_valid_i && (in_req_i.action == ACT_LOOKUP) && valid_q &&
                 ((in_req_i.lookup_addr & mask_q) == prefix_q);
  assign take  = match && (!in_acc_i.hit || (mask_q >= in_acc_i.best_mask));

  always_comb begin
    acc_d = in_acc_i;
    if (take) begin
      acc_d.hit         = 1'b1;
      acc_d.match_index = CellTag;
      acc_d.best_mask   = mask_q;
      acc_d.next_hop    = gateway_q;
      acc_d.out_port    = port_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_i) begin
        out_valid_q <= in_valid_i;
      end
      if (wr_hit) begin
        valid_q <= in_req_i.entry_enable;
      end
    end
  end

  // entry fields and stage payload
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      prefix_q  <= in_req_i.prefix_in;
      mask_q    <= in_req_i.mask_in;
      gateway_q <= in_req_i.gateway_in;
      port_q    <= in_req_i.port_in;
    end
    if (adv_i) begin
      out_req_q <= in_req_i;
      out_acc_q <= acc_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;
  assign out_acc_o   = out_acc_q;

`ifndef SYNTH
  // a miss carries all-zero result fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_acc_q.hit |->
      (out_acc_q.match_index == '0) && (out_acc_q.next_hop == '0) &&
      (out_acc_q.out_port == '0))
    else $error("miss with nonzero result fields");

  // write requests never report a hit
  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_req_q.action == ACT_WRITE) |-> !out_acc_q.hit)
    else $error("write request reported a hit");

  // a stalled stage keeps its occupancy
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> out_valid_q == $past(out_valid_q))
    else $error("stage moved while stalled");

  // a write to this slot loads its valid bit from the entry enable
  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_hit |=> valid_q == $past(in_req_i.entry_enable))
    else $error("slot valid bit not updated by write");
`endif

endmodule

// File: tb/tb_longest_prefix_route_lookup_unit.sv
// ----------------------------------------------------------------------------
// tb_longest_prefix_route_lookup_unit
// Checks the longest prefix route lookup unit against a route table model
// kept in the bench. Writes and lookups go in through the request channel,
// with random gaps in the pacing phase. Each result is compared with the
// oldest predicted route. Phases cover a directed table, back to back
// traffic, random pacing and a long output stall that backs up the chain.
// ----------------------------------------------------------------------------
module tb_longest_prefix_route_lookup_unit;
  import lpm_pkg::*;

  localparam int unsigned TableEntries = LPM_TABLE_ENTRIES;

  // one predicted or observed lookup result
  typedef struct packed {
    logic              hit;
    logic [IndexW-1:0] match_index;
    logic [AddrW-1:0]  next_hop;
    logic [PortW-1:0]  out_port;
  } route_res_t;

  logic clk_i;
  logic rst_ni;

  lpm_req_if req_if ();
  lpm_res_if res_if ();

  longest_prefix_route_lookup_unit #(
    .TABLE_ENTRIES(TableEntries)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // bench copy of the routing table
  logic             tbl_valid   [TableEntries];
  logic [AddrW-1:0] tbl_prefix  [TableEntries];
  logic [AddrW-1:0] tbl_mask    [TableEntries];
  logic [AddrW-1:0] tbl_gateway [TableEntries];
  logic [PortW-1:0] tbl_port    [TableEntries];

  route_res_t  pending_routes[$];
  int unsigned fail_count;
  bit          pace_gaps;
  int unsigned hold_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!pace_gaps || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // table update and longest prefix search for one accepted request
  function automatic route_res_t route_table_step(req_t r);
    route_res_t       res;
    logic             found;
    logic [AddrW-1:0] best_mask;
    res   = '0;
    found = 1'b0;
    best_mask = '0;
    if (r.action == ACT_WRITE) begin
      if (r.entry_index < TableEntries) begin
        tbl_valid[r.entry_index]   = r.entry_enable;
        tbl_prefix[r.entry_index]  = r.prefix_in;
        tbl_mask[r.entry_index]    = r.mask_in;
        tbl_gateway[r.entry_index] = r.gateway_in;
        tbl_port[r.entry_index]    = r.port_in;
      end
      return res;
    end
    for (int i = 0; i < TableEntries; i++) begin
      // greater or equal mask lets the higher slot win a tie
      if (tbl_valid[i] && ((r.lookup_addr & tbl_mask[i]) == tbl_prefix[i]) &&
          (!found || tbl_mask[i] >= best_mask)) begin
        found           = 1'b1;
        best_mask       = tbl_mask[i];
        res.hit         = 1'b1;
        res.match_index = IndexW'(i);
        res.next_hop    = tbl_gateway[i];
        res.out_port    = tbl_port[i];
      end
    end
    return res;
  endfunction

  // contiguous network mask of a given length
  function automatic logic [AddrW-1:0] prefix_mask(int unsigned len);
    if (len == 0) return '0;
    return ~(AddrW'(0)) << (AddrW - len);
  endfunction

  function automatic req_t write_item(logic [IndexW-1:0] idx, logic en,
                                      logic [AddrW-1:0] prefix,
                                      logic [AddrW-1:0] mask,
                                      logic [AddrW-1:0] gw,
                                      logic [PortW-1:0] port);
    req_t r;
    r.action       = ACT_WRITE;
    r.entry_index  = idx;
    r.entry_enable = en;
    r.prefix_in    = prefix;
    r.mask_in      = mask;
    r.gateway_in   = gw;
    r.port_in      = port;
    r.lookup_addr  = $urandom;
    return r;
  endfunction

  // lookup with random content in the fields it ignores
  function automatic req_t lookup_item(logic [AddrW-1:0] addr);
    req_t r;
    r.action       = ACT_LOOKUP;
    r.entry_index  = IndexW'($urandom);
    r.entry_enable = 1'($urandom);
    r.prefix_in    = $urandom;
    r.mask_in      = $urandom;
    r.gateway_in   = $urandom;
    r.port_in      = PortW'($urandom);
    r.lookup_addr  = addr;
    return r;
  endfunction

  // offer one request, predict its result once accepted, then maybe idle
  task automatic send_request(input req_t r);
    int unsigned gap;
    req_if.valid        <= 1'b1;
    req_if.action       <= r.action;
    req_if.entry_index  <= r.entry_index;
    req_if.entry_enable <= r.entry_enable;
    req_if.prefix_in    <= r.prefix_in;
    req_if.mask_in      <= r.mask_in;
    req_if.gateway_in   <= r.gateway_in;
    req_if.port_in      <= r.port_in;
    req_if.lookup_addr  <= r.lookup_addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_routes.push_back(route_table_step(r));
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result side: random ready, long hold-off on demand, compare each result
  initial begin
    route_res_t  exp_res;
    int unsigned off_count;
    off_count = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (pending_routes.size() == 0) begin
          $error("result with no request pending: hit %0b index %0d", res_if.hit,
                 res_if.match_index);
          fail_count++;
        end else begin
          exp_res = pending_routes.pop_front();
          if (res_if.hit !== exp_res.hit) begin
            $error("hit: expected %0b actual %0b", exp_res.hit, res_if.hit);
            fail_count++;
          end
          if (res_if.match_index !== exp_res.match_index) begin
            $error("match_index: expected %0d actual %0d", exp_res.match_index,
                   res_if.match_index);
            fail_count++;
          end
          if (res_if.next_hop !== exp_res.next_hop) begin
            $error("next_hop: expected %h actual %h", exp_res.next_hop, res_if.next_hop);
            fail_count++;
          end
          if (res_if.out_port !== exp_res.out_port) begin
            $error("out_port: expected %0d actual %0d", exp_res.out_port,
                   res_if.out_port);
            fail_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else if (off_count > 0) begin
        res_if.ready <= 1'b0;
        off_count--;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) off_count = pick_gap();
      end
    end
  end

  // empty table: every lookup misses
  task automatic test_empty_table();
    send_request(lookup_item(32'h0000_0000));
    send_request(lookup_item(32'hFFFF_FFFF));
  endtask

  // hand-built table: default route, nested prefixes, ties, clears
  task automatic test_directed_routes();
    send_request(write_item(4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000,
                            32'h0A00_0001, 2'd1));
    send_request(write_item(4'd3, 1'b1, 32'h0A00_0000, prefix_mask(8),
                            32'h0A00_0003, 2'd2));
    send_request(write_item(4'd5, 1'b1, 32'h0A01_0200, prefix_mask(24),
                            32'h0A01_0201, 2'd3));
    send_request(write_item(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 2'd3));
    // same mask on two slots, higher slot must win
    send_request(write_item(4'd7, 1'b1, 32'h0A01_0000, prefix_mask(16),
                            32'h0A01_0007, 2'd0));
    send_request(write_item(4'd9, 1'b1, 32'h0A01_0000, prefix_mask(16),
                            32'h0A01_0009, 2'd1));
    // prefix bits outside the mask, never matches
    send_request(write_item(4'd12, 1'b1, 32'hC0A8_0001, prefix_mask(24),
                            32'hC0A8_00FE, 2'd2));
    send_request(lookup_item(32'h0A01_0203));
    send_request(lookup_item(32'h0A01_FF00));
    send_request(lookup_item(32'h0AFF_0000));
    send_request(lookup_item(32'hFFFF_FFFF));
    send_request(lookup_item(32'hC0A8_0001));
    send_request(lookup_item(32'h0000_0000));
    // cleared slot keeps its fields but drops out of the search
    send_request(write_item(4'd5, 1'b0, 32'h0A01_0200, prefix_mask(24),
                            32'h0A01_0201, 2'd3));
    send_request(lookup_item(32'h0A01_0203));
    send_request(write_item(4'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
                            32'h0A00_0001, 2'd1));
    send_request(lookup_item(32'hC0A8_0001));
    // host route to address zero with zero gateway
    send_request(write_item(4'd12, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF,
                            32'h0000_0000, 2'd0));
    send_request(lookup_item(32'h0000_0000));
  endtask

  // mostly well-formed routes and lookups aimed at them, some noise
  task automatic random_requests(input int unsigned count);
    int unsigned      roll;
    int unsigned      slot;
    logic [AddrW-1:0] mask;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        mask = prefix_mask($urandom_range(0, 32));
        send_request(write_item(IndexW'($urandom), $urandom_range(0, 9) != 0,
                                $urandom & mask, mask, $urandom,
                                PortW'($urandom)));
      end else if (roll < 38) begin
        send_request(write_item(IndexW'($urandom), 1'($urandom), $urandom,
                                $urandom, $urandom, PortW'($urandom)));
      end else if (roll < 85) begin
        slot = $urandom_range(0, TableEntries - 1);
        if (tbl_valid[slot])
          send_request(lookup_item(tbl_prefix[slot] | ($urandom & ~tbl_mask[slot])));
        else
          send_request(lookup_item($urandom));
      end else begin
        send_request(lookup_item($urandom));
      end
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    pace_gaps = 1'b0;
    random_requests(100);
  endtask

  // random pacing on both sides
  task automatic test_random_pacing();
    pace_gaps = 1'b1;
    random_requests(550);
  endtask

  // output held off long enough for the chain to fill and stall requests
  task automatic test_output_stall();
    pace_gaps   = 1'b0;
    hold_cycles = 300;
    random_requests(100);
  endtask

  // main sequence
  initial begin
    fail_count  = 0;
    pace_gaps   = 1'b0;
    hold_cycles = 0;
    for (int i = 0; i < TableEntries; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_prefix[i]  = '0;
      tbl_mask[i]    = '0;
      tbl_gateway[i] = '0;
      tbl_port[i]    = '0;
    end
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_WRITE;
    req_if.entry_index  <= '0;
    req_if.entry_enable <= 1'b0;
    req_if.prefix_in    <= '0;
    req_if.mask_in      <= '0;
    req_if.gateway_in   <= '0;
    req_if.port_in      <= '0;
    req_if.lookup_addr  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_directed_routes();
    test_back_to_back();
    test_random_pacing();
    test_output_stall();

    req_if.valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (2 * TableEntries + 8) @(posedge clk_i);
    if (pending_routes.size() != 0) begin
      $error("%0d results never arrived", pending_routes.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
rtl/lpm_pkg.sv
rtl/lpm_req_if.sv
rtl/lpm_res_if.sv
rtl/lpm_cell.sv
rtl/longest_prefix_route_lookup_unit.sv
tb/tb_longest_prefix_route_lookup_unit.sv
